>>> hw/rtl/pts_pkg.sv
package pts_pkg;

  localparam int MAX_THREADS    = 8;
  localparam int NUM_SEMAPHORES = 4;
  localparam int THREAD_W       = $clog2(MAX_THREADS);
  localparam int COUNT_W        = $clog2(MAX_THREADS + 1);
  localparam int SEM_W          = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int PRIO_W         = 8;
  localparam int TICK_W         = 32;

  typedef enum logic [2:0] {
    KIND_CREATE  = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_DELAY   = 3'd2,
    KIND_WAIT    = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_DELAY = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       scheduled;
    logic       next_valid;
    logic [2:0] next_thread;
    logic       switch_request;
    err_e       error;
  } result_t;

  typedef struct packed {
    logic              used;
    logic              ready;
    logic [PRIO_W-1:0] prio;
    logic [TICK_W-1:0] timer;
    logic              best_found;
    logic [PRIO_W-1:0] best_prio;
    logic              idle_found;
  } slot_in_t;

  typedef struct packed {
    logic              timer_we;
    logic [TICK_W-1:0] timer_dec;
    logic              ready_set;
    logic              take_best;
    logic              take_idle;
  } slot_out_t;

endpackage

>>> hw/rtl/pts_evt_if.sv
interface pts_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  priority_req;
  logic [31:0] delay_ticks;
  logic [1:0]  semaphore_index;

  modport source (
    output valid, kind, priority_req, delay_ticks, semaphore_index,
    input  ready
  );

  modport sink (
    input  valid, kind, priority_req, delay_ticks, semaphore_index,
    output ready
  );
endinterface

>>> hw/rtl/pts_res_if.sv
interface pts_res_if;
  logic       valid;
  logic       ready;
  logic       scheduled;
  logic       next_valid;
  logic [2:0] next_thread;
  logic       switch_request;
  logic [1:0] error;

  modport source (
    output valid, scheduled, next_valid, next_thread, switch_request, error,
    input  ready
  );

  modport sink (
    input  valid, scheduled, next_valid, next_thread, switch_request, error,
    output ready
  );
endinterface

>>> hw/rtl/priority_thread_scheduler.sv
// tick, delay, wait and release visit one slot per cycle through a single slot unit:
// the result register is loaded from ST_DONE once the last slot has been visited
// create, unknown and rejected events go straight to ST_DONE and then to the result register
// a new event is taken only in ST_IDLE, so not before the last one has finished
// a previous result beat still waiting holds the finished event until it leaves
// rst_ni clears the thread table, running thread and semaphore waiters asynchronously
module priority_thread_scheduler (
  input logic      clk_i,
  input logic      rst_ni,
  pts_evt_if.sink  evt_i,
  pts_res_if.source res_o
);
  import pts_pkg::*;

  state_e state_q, state_d;
  logic [THREAD_W-1:0] cnt_q, cnt_d;
  logic last;

  logic [MAX_THREADS-1:0] used_q, used_d;
  logic [MAX_THREADS-1:0] idle_q, idle_d;
  logic [MAX_THREADS-1:0] ready_q, ready_d;
  logic [PRIO_W-1:0] prio_q [MAX_THREADS];
  logic [TICK_W-1:0] timer_q [MAX_THREADS];
  logic [THREAD_W-1:0] waiter_q [NUM_SEMAPHORES];
  logic [NUM_SEMAPHORES-1:0] waiter_valid_q, waiter_valid_d;

  logic [COUNT_W-1:0] created_q, created_d;
  logic [THREAD_W-1:0] run_q, run_d;
  logic run_valid_q, run_valid_d;

  logic best_found_q, best_found_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic [THREAD_W-1:0] best_q, best_d;
  logic idle_found_q, idle_found_d;
  logic [THREAD_W-1:0] idle_pick_q, idle_pick_d;

  result_t pend_q, pend_d;
  result_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic timer_we;
  logic [THREAD_W-1:0] timer_wa;
  logic [TICK_W-1:0] timer_wd;
  logic prio_we;
  logic waiter_we;

  kind_e kind;
  logic accept, out_free, full, delay_bad, sem_ok;
  logic [SEM_W-1:0] sem;
  logic [THREAD_W-1:0] slot_new;
  logic fin_best_found, fin_idle_found, found;
  logic [THREAD_W-1:0] fin_best, fin_idle, pick;

  slot_in_t  slot_in;
  slot_out_t slot_out;

  pts_slot_unit u_slot (
    .slot_i (slot_in),
    .slot_o (slot_out)
  );

  always_comb begin
    kind      = kind_e'(evt_i.kind);
    accept    = evt_i.valid && evt_i.ready;
    out_free  = !res_valid_q || res_o.ready;
    last      = (cnt_q == THREAD_W'(MAX_THREADS - 1));
    full      = (created_q >= COUNT_W'(MAX_THREADS));
    delay_bad = !run_valid_q || idle_q[run_q];
    sem_ok    = (int'(evt_i.semaphore_index) < NUM_SEMAPHORES);
    sem       = SEM_W'(evt_i.semaphore_index);
    slot_new  = THREAD_W'(created_q);

    slot_in.used       = used_q[cnt_q];
    slot_in.ready      = ready_q[cnt_q];
    slot_in.prio       = prio_q[cnt_q];
    slot_in.timer      = timer_q[cnt_q];
    slot_in.best_found = best_found_q;
    slot_in.best_prio  = best_prio_q;
    slot_in.idle_found = idle_found_q;

    fin_best_found = best_found_q || slot_out.take_best;
    fin_best       = slot_out.take_best ? cnt_q : best_q;
    fin_idle_found = idle_found_q || slot_out.take_idle;
    fin_idle       = slot_out.take_idle ? cnt_q : idle_pick_q;
    found          = fin_best_found || fin_idle_found;
    pick           = fin_best_found ? fin_best : fin_idle;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_TICK:    state_d = ST_TICK;
            KIND_DELAY:   state_d = delay_bad ? ST_DONE : ST_SCAN;
            KIND_WAIT,
            KIND_RELEASE: state_d = sem_ok ? ST_SCAN : ST_DONE;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: if (last) state_d = ST_DONE;
      ST_SCAN: if (last) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    evt_i.ready = (state_q == ST_IDLE);

    cnt_d          = cnt_q;
    used_d         = used_q;
    idle_d         = idle_q;
    ready_d        = ready_q;
    waiter_valid_d = waiter_valid_q;
    created_d      = created_q;
    run_d          = run_q;
    run_valid_d    = run_valid_q;
    best_found_d   = best_found_q;
    best_prio_d    = best_prio_q;
    best_d         = best_q;
    idle_found_d   = idle_found_q;
    idle_pick_d    = idle_pick_q;
    pend_d         = pend_q;
    res_d          = res_q;
    res_valid_d    = res_valid_q;
    timer_we       = 1'b0;
    timer_wa       = cnt_q;
    timer_wd       = slot_out.timer_dec;
    prio_we        = 1'b0;
    waiter_we      = 1'b0;

    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d        = '0;
          best_found_d = 1'b0;
          idle_found_d = 1'b0;
          pend_d       = '0;
          case (kind)
            KIND_CREATE: begin
              if (full) begin
                pend_d.error = ERR_FULL;
              end else begin
                used_d[slot_new]  = 1'b1;
                idle_d[slot_new]  = (evt_i.priority_req == '0);
                ready_d[slot_new] = (evt_i.priority_req != '0);
                prio_we           = 1'b1;
                timer_we          = 1'b1;
                timer_wa          = slot_new;
                timer_wd          = '0;
                created_d         = created_q + COUNT_W'(1);
              end
            end
            KIND_DELAY: begin
              if (delay_bad) begin
                pend_d.error = ERR_DELAY;
              end else begin
                timer_we        = 1'b1;
                timer_wa        = run_q;
                timer_wd        = evt_i.delay_ticks;
                ready_d[run_q]  = 1'b0;
              end
            end
            KIND_WAIT: begin
              if (sem_ok && run_valid_q) begin
                ready_d[run_q]      = 1'b0;
                waiter_we           = 1'b1;
                waiter_valid_d[sem] = 1'b1;
              end
            end
            KIND_RELEASE: begin
              if (sem_ok && waiter_valid_q[sem]) begin
                ready_d[waiter_q[sem]] = 1'b1;
                waiter_valid_d[sem]    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        cnt_d    = cnt_q + THREAD_W'(1);
        timer_we = slot_out.timer_we;
        if (slot_out.ready_set) ready_d[cnt_q] = 1'b1;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + THREAD_W'(1);
        if (slot_out.take_best) begin
          best_found_d = 1'b1;
          best_prio_d  = slot_in.prio;
          best_d       = cnt_q;
        end
        if (slot_out.take_idle) begin
          idle_found_d = 1'b1;
          idle_pick_d  = cnt_q;
        end
        if (last) begin
          pend_d.scheduled      = 1'b1;
          pend_d.next_valid     = found;
          pend_d.next_thread    = found ? 3'(pick) : 3'd0;
          pend_d.switch_request = found && (!run_valid_q || (run_q != pick));
          pend_d.error          = ERR_NONE;
          if (found) begin
            run_d       = pick;
            run_valid_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    res_o.valid          = res_valid_q;
    res_o.scheduled      = res_q.scheduled;
    res_o.next_valid     = res_q.next_valid;
    res_o.next_thread    = res_q.next_thread;
    res_o.switch_request = res_q.switch_request;
    res_o.error          = 2'(res_q.error);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      used_q         <= '0;
      idle_q         <= '0;
      ready_q        <= '0;
      waiter_valid_q <= '0;
      created_q      <= '0;
      run_q          <= '0;
      run_valid_q    <= 1'b0;
      best_found_q   <= 1'b0;
      idle_found_q   <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      used_q         <= used_d;
      idle_q         <= idle_d;
      ready_q        <= ready_d;
      waiter_valid_q <= waiter_valid_d;
      created_q      <= created_d;
      run_q          <= run_d;
      run_valid_q    <= run_valid_d;
      best_found_q   <= best_found_d;
      idle_found_q   <= idle_found_d;
      res_valid_q    <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_q      <= best_d;
    idle_pick_q <= idle_pick_d;
    pend_q      <= pend_d;
    res_q       <= res_d;
    if (timer_we) timer_q[timer_wa] <= timer_wd;
    if (prio_we) prio_q[slot_new] <= evt_i.priority_req;
    if (waiter_we) waiter_q[sem] <= run_q;
  end

endmodule

>>> hw/rtl/pts_slot_unit.sv
module pts_slot_unit (
  input  pts_pkg::slot_in_t  slot_i,
  output pts_pkg::slot_out_t slot_o
);
  import pts_pkg::*;

  logic blocked;

  always_comb begin
    blocked          = slot_i.used && (slot_i.prio != '0) && !slot_i.ready;
    slot_o.timer_we  = blocked;
    slot_o.timer_dec = slot_i.timer - TICK_W'(1);
    slot_o.ready_set = blocked && (slot_o.timer_dec == '0);
    slot_o.take_best = slot_i.used && slot_i.ready &&
                       (!slot_i.best_found || (slot_i.prio > slot_i.best_prio));
    slot_o.take_idle = slot_i.used && (slot_i.prio == '0) && !slot_i.idle_found;
  end

endmodule
